>>> design/bgs_pkg.sv
// Shared types and constants for the barrier gate sequencer.
// No dependencies; every other design file imports this package.
package bgs_pkg;

  localparam int SLOTS     = 8;
  localparam int MASK_W    = 8;
  localparam int SLOT_W    = 4;
  localparam int COUNT_W   = 4;
  localparam int HOLD_W    = 8;
  localparam int TIMEOUT_W = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 16;

  localparam logic [SLOT_W-1:0]    NO_SLOT         = SLOT_W'(8);
  localparam logic [HOLD_W-1:0]    HOLD_MAX        = 8'hFF;
  localparam logic [HOLD_W-1:0]    DEBOUNCE_RESET  = 8'd50;
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET   = 16'd5000;

  typedef enum logic [2:0] {
    OP_TICK       = 3'd0,
    OP_OPEN_ENTRY = 3'd1,
    OP_OPEN_EXIT  = 3'd2,
    OP_CLR_PRESS  = 3'd3,
    OP_CLR_DONE   = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_PARK = 2'd1,
    MODE_EXIT = 2'd2
  } gate_mode_t;

  typedef enum logic [1:0] {
    KIND_NONE  = 2'd0,
    KIND_ENTRY = 2'd1,
    KIND_EXIT  = 2'd2
  } done_kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEBOUNCE = 2'd0,
    REG_TIMEOUT  = 2'd1,
    REG_PRESSED  = 2'd2
  } cfg_reg_t;

  // Gate state after the current item, handed from the gate controller to the top.
  typedef struct packed {
    logic              entry_open;
    logic              exit_open;
    gate_mode_t        mode;
    logic              done_flag;
    done_kind_t        done_kind;
    logic [SLOT_W-1:0] done_slot;
  } gate_status_t;

  typedef struct packed {
    logic              entry_press_pending;
    logic              exit_press_pending;
    logic              entry_barrier_open;
    logic              exit_barrier_open;
    logic [1:0]        gate_mode;
    logic              completed_flag;
    logic [1:0]        completed_kind;
    logic [SLOT_W-1:0] completed_slot;
    logic              entry_allowed;
    logic              exit_allowed;
  } result_t;

endpackage

>>> design/bgs_if.sv
// Channel interfaces: command input, result output and configuration write.
// Depends on bgs_pkg for field widths.
interface bgs_in_if;
  import bgs_pkg::*;
  logic               valid;
  logic               ready;
  logic [2:0]         opcode;
  logic               entry_button_pin;
  logic               exit_button_pin;
  logic [MASK_W-1:0]  slot_mask;
  logic               lot_full;
  logic [COUNT_W-1:0] occupied_count;

  modport source (output valid, opcode, entry_button_pin, exit_button_pin, slot_mask,
                  lot_full, occupied_count, input ready);
  modport sink   (input valid, opcode, entry_button_pin, exit_button_pin, slot_mask,
                  lot_full, occupied_count, output ready);
endinterface

interface bgs_out_if;
  import bgs_pkg::*;
  logic              valid;
  logic              ready;
  logic              entry_press_pending;
  logic              exit_press_pending;
  logic              entry_barrier_open;
  logic              exit_barrier_open;
  logic [1:0]        gate_mode;
  logic              completed_flag;
  logic [1:0]        completed_kind;
  logic [SLOT_W-1:0] completed_slot;
  logic              entry_allowed;
  logic              exit_allowed;

  modport source (output valid, entry_press_pending, exit_press_pending, entry_barrier_open,
                  exit_barrier_open, gate_mode, completed_flag, completed_kind,
                  completed_slot, entry_allowed, exit_allowed, input ready);
  modport sink   (input valid, entry_press_pending, exit_press_pending, entry_barrier_open,
                  exit_barrier_open, gate_mode, completed_flag, completed_kind,
                  completed_slot, entry_allowed, exit_allowed, output ready);
endinterface

interface bgs_cfg_if;
  import bgs_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> design/bgs_debounce.sv
// Tick-driven button debouncer with rising-press detect.
// Depends on bgs_pkg.
module bgs_debounce (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic                       level,
  input  logic                       pressed_level,
  input  logic [bgs_pkg::HOLD_W-1:0] hold_limit,
  output logic                       rise
);
  import bgs_pkg::*;

  logic              raw_r, raw_nxt;
  logic              stable_r, stable_nxt;
  logic [HOLD_W-1:0] hold_r, hold_nxt;
  logic              p;

  assign p = (level == pressed_level);

  always_comb begin
    raw_nxt    = raw_r;
    stable_nxt = stable_r;
    hold_nxt   = hold_r;
    rise       = 1'b0;
    if (p != raw_r) begin
      raw_nxt  = p;
      hold_nxt = '0;
    end else begin
      if (hold_r != HOLD_MAX) hold_nxt = hold_r + HOLD_W'(1);
      if (p != stable_r && hold_nxt >= hold_limit) begin
        stable_nxt = p;
        rise       = p;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      raw_r    <= 1'b0;
      stable_r <= 1'b0;
      hold_r   <= '0;
    end else if (en) begin
      raw_r    <= raw_nxt;
      stable_r <= stable_nxt;
      hold_r   <= hold_nxt;
    end
  end

endmodule

>>> design/bgs_gate_ctrl.sv
// Gate controller: mode, barriers, shared wait countdown, reference mask
// and completion record. Depends on bgs_pkg.
module bgs_gate_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          upd,
  input  logic [2:0]                    opcode,
  input  logic [bgs_pkg::MASK_W-1:0]    slot_mask,
  input  logic                          lot_full,
  input  logic [bgs_pkg::COUNT_W-1:0]   occupied_count,
  input  logic [bgs_pkg::TIMEOUT_W-1:0] timeout_ticks,
  output bgs_pkg::gate_status_t         status_nxt
);
  import bgs_pkg::*;

  gate_status_t         st_r;
  logic [TIMEOUT_W-1:0] cd_r, cd_nxt, cd_dec;
  logic [MASK_W-1:0]    ref_r, ref_nxt;
  logic [SLOT_W-1:0]    hit_slot;
  logic                 want;
  logic                 fin;

  // lowest slot whose bit changed and now reads as want
  function automatic logic [SLOT_W-1:0] find_slot(input logic [MASK_W-1:0] old_m,
                                                  input logic [MASK_W-1:0] new_m,
                                                  input logic w);
    logic [SLOT_W-1:0] res;
    res = NO_SLOT;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if ((old_m[i] ^ new_m[i]) && (new_m[i] == w)) res = SLOT_W'(i);
    end
    return res;
  endfunction

  assign want     = (st_r.mode == MODE_PARK);
  assign hit_slot = find_slot(ref_r, slot_mask, want);
  assign cd_dec   = (cd_r != '0) ? cd_r - TIMEOUT_W'(1) : cd_r;

  always_comb begin
    status_nxt = st_r;
    cd_nxt     = cd_r;
    ref_nxt    = ref_r;
    fin        = 1'b0;
    case (opcode)
      OP_TICK: begin
        if (st_r.mode == MODE_PARK || st_r.mode == MODE_EXIT) begin
          if (hit_slot != NO_SLOT) begin
            status_nxt.done_flag = 1'b1;
            status_nxt.done_kind = want ? KIND_ENTRY : KIND_EXIT;
            status_nxt.done_slot = hit_slot;
            fin = 1'b1;
          end else begin
            cd_nxt = cd_dec;
            fin    = (cd_dec == '0);
          end
          if (fin) begin
            if (want) status_nxt.entry_open = 1'b0;
            else      status_nxt.exit_open  = 1'b0;
            status_nxt.mode = MODE_IDLE;
          end
        end
        if (status_nxt.mode == MODE_IDLE) ref_nxt = slot_mask;
        if (lot_full) begin
          status_nxt.entry_open = 1'b0;
          if (status_nxt.mode == MODE_PARK) status_nxt.mode = MODE_IDLE;
        end
      end
      OP_OPEN_ENTRY: begin
        if (st_r.mode == MODE_IDLE && !lot_full) begin
          status_nxt.entry_open = 1'b1;
          status_nxt.exit_open  = 1'b0;
          status_nxt.mode       = MODE_PARK;
          status_nxt.done_flag  = 1'b0;
          status_nxt.done_kind  = KIND_NONE;
          status_nxt.done_slot  = NO_SLOT;
          ref_nxt = slot_mask;
          cd_nxt  = timeout_ticks;
        end
      end
      OP_OPEN_EXIT: begin
        if (st_r.mode == MODE_IDLE && occupied_count != '0) begin
          status_nxt.entry_open = 1'b0;
          status_nxt.exit_open  = 1'b1;
          status_nxt.mode       = MODE_EXIT;
          status_nxt.done_flag  = 1'b0;
          status_nxt.done_kind  = KIND_NONE;
          status_nxt.done_slot  = NO_SLOT;
          ref_nxt = slot_mask;
          cd_nxt  = timeout_ticks;
        end
      end
      OP_CLR_DONE: begin
        status_nxt.done_flag = 1'b0;
        status_nxt.done_kind = KIND_NONE;
        status_nxt.done_slot = NO_SLOT;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.entry_open <= 1'b0;
      st_r.exit_open  <= 1'b0;
      st_r.mode       <= MODE_IDLE;
      st_r.done_flag  <= 1'b0;
      st_r.done_kind  <= KIND_NONE;
      st_r.done_slot  <= NO_SLOT;
      cd_r            <= '0;
      ref_r           <= '0;
    end else if (upd) begin
      st_r  <= status_nxt;
      cd_r  <= cd_nxt;
      ref_r <= ref_nxt;
    end
  end

endmodule

>>> design/barrier_gate_sequencer.sv
// Barrier gate sequencer: top level with config registers, press latches,
// debouncers, gate controller and a two-entry result buffer.
// Each result is registered into the head register, or the skid slot while stalled.
// Throughput: one item per cycle; in_ch stalls only when both result slots are full.
// Reset (synchronous, rst_n low): all gate and button state cleared, completion slot
// set to none, registers back to debounce 50, timeout 5000, active-low buttons.
module barrier_gate_sequencer (
  input logic       clk,
  input logic       rst_n,
  bgs_in_if.sink    in_ch,
  bgs_out_if.source out_ch,
  bgs_cfg_if.sink   cfg_ch
);
  import bgs_pkg::*;

  // configuration registers, written only while the block is quiet: a rule on the user that the block leaves unenforced
  logic [HOLD_W-1:0]    debounce_r;
  logic [TIMEOUT_W-1:0] timeout_r;
  logic                 pressed_r;

  logic [1:0]   press_r, press_nxt;
  logic         accept;
  logic         tick;
  logic         entry_rise, exit_rise;
  gate_status_t gate_nxt;
  result_t      res_nxt;

  // result buffer: head register plus a skid slot behind it
  result_t out_r, skid_r;
  logic    out_valid_r, skid_valid_r;
  logic    pop;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r <= DEBOUNCE_RESET;
      timeout_r  <= TIMEOUT_RESET;
      pressed_r  <= 1'b0;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_DEBOUNCE: debounce_r <= cfg_ch.data[HOLD_W-1:0];
        REG_TIMEOUT:  timeout_r  <= cfg_ch.data[TIMEOUT_W-1:0];
        REG_PRESSED:  pressed_r  <= cfg_ch.data[0];
        default: begin
        end
      endcase
    end
  end

  // accept as long as the skid slot is free
  assign in_ch.ready = !skid_valid_r;
  assign accept      = in_ch.valid && in_ch.ready;
  assign tick        = accept && (in_ch.opcode == OP_TICK);

  bgs_debounce u_entry_db (
    .clk           (clk),
    .rst_n         (rst_n),
    .en            (tick),
    .level         (in_ch.entry_button_pin),
    .pressed_level (pressed_r),
    .hold_limit    (debounce_r),
    .rise          (entry_rise)
  );

  bgs_debounce u_exit_db (
    .clk           (clk),
    .rst_n         (rst_n),
    .en            (tick),
    .level         (in_ch.exit_button_pin),
    .pressed_level (pressed_r),
    .hold_limit    (debounce_r),
    .rise          (exit_rise)
  );

  bgs_gate_ctrl u_gate (
    .clk            (clk),
    .rst_n          (rst_n),
    .upd            (accept),
    .opcode         (in_ch.opcode),
    .slot_mask      (in_ch.slot_mask),
    .lot_full       (in_ch.lot_full),
    .occupied_count (in_ch.occupied_count),
    .timeout_ticks  (timeout_r),
    .status_nxt     (gate_nxt)
  );

  // press latches: set by debounced rising press on a tick, cleared by command
  always_comb begin
    press_nxt = press_r;
    case (in_ch.opcode)
      OP_TICK:      press_nxt = press_r | {exit_rise, entry_rise};
      OP_CLR_PRESS: press_nxt = 2'b00;
      default: begin
      end
    endcase
  end

  always_comb begin
    res_nxt.entry_press_pending = press_nxt[0];
    res_nxt.exit_press_pending  = press_nxt[1];
    res_nxt.entry_barrier_open  = gate_nxt.entry_open;
    res_nxt.exit_barrier_open   = gate_nxt.exit_open;
    res_nxt.gate_mode           = gate_nxt.mode;
    res_nxt.completed_flag      = gate_nxt.done_flag;
    res_nxt.completed_kind      = gate_nxt.done_kind;
    res_nxt.completed_slot      = gate_nxt.done_slot;
    // allowed flags use this item's lot_full and occupied_count
    res_nxt.entry_allowed       = (gate_nxt.mode == MODE_IDLE) && !in_ch.lot_full;
    res_nxt.exit_allowed        = (gate_nxt.mode == MODE_IDLE) && (in_ch.occupied_count != '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      press_r <= 2'b00;
    end else if (accept) begin
      press_r <= press_nxt;
    end
  end

  assign pop = out_valid_r && out_ch.ready;

  // skid slot never fills during a pop: a new item goes to the head, or ready is low
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (pop) begin
      if (skid_valid_r) begin
        out_r        <= skid_r;
        skid_valid_r <= 1'b0;
      end else if (accept) begin
        out_r <= res_nxt;
      end else begin
        out_valid_r <= 1'b0;
      end
    end else if (accept) begin
      if (!out_valid_r) begin
        out_r       <= res_nxt;
        out_valid_r <= 1'b1;
      end else begin
        skid_r       <= res_nxt;
        skid_valid_r <= 1'b1;
      end
    end
  end

  assign out_ch.valid               = out_valid_r;
  assign out_ch.entry_press_pending = out_r.entry_press_pending;
  assign out_ch.exit_press_pending  = out_r.exit_press_pending;
  assign out_ch.entry_barrier_open  = out_r.entry_barrier_open;
  assign out_ch.exit_barrier_open   = out_r.exit_barrier_open;
  assign out_ch.gate_mode           = out_r.gate_mode;
  assign out_ch.completed_flag      = out_r.completed_flag;
  assign out_ch.completed_kind      = out_r.completed_kind;
  assign out_ch.completed_slot      = out_r.completed_slot;
  assign out_ch.entry_allowed       = out_r.entry_allowed;
  assign out_ch.exit_allowed        = out_r.exit_allowed;

endmodule

>>> design/bgs_checker.sv
// Port-level assertions for barrier_gate_sequencer, attached by bind.
// Depends on bgs_pkg.
module bgs_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic                       entry_open,
  input logic                       exit_open,
  input logic [1:0]                 gate_mode,
  input logic                       completed_flag,
  input logic [1:0]                 completed_kind,
  input logic [bgs_pkg::SLOT_W-1:0] completed_slot,
  input logic                       entry_allowed
);
  import bgs_pkg::*;

  // a held result keeps its gate mode and completed slot
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(gate_mode) && $stable(completed_slot))
    else $error("result changed while stalled");

  // a transfer into an empty buffer shows up next cycle
  a_in_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !out_valid |=> out_valid)
    else $error("accepted item produced no result");

  // idle means both barriers are down
  a_idle_closed: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && gate_mode == MODE_IDLE |-> !entry_open && !exit_open)
    else $error("barrier open while idle");

  a_allowed_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && entry_allowed |-> gate_mode == MODE_IDLE)
    else $error("entry allowed outside idle");

  // no completion recorded means empty kind and slot
  a_done_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !completed_flag |-> completed_kind == KIND_NONE && completed_slot == NO_SLOT)
    else $error("stale completion fields");

endmodule

bind barrier_gate_sequencer bgs_checker u_bgs_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .entry_open     (out_ch.entry_barrier_open),
  .exit_open      (out_ch.exit_barrier_open),
  .gate_mode      (out_ch.gate_mode),
  .completed_flag (out_ch.completed_flag),
  .completed_kind (out_ch.completed_kind),
  .completed_slot (out_ch.completed_slot),
  .entry_allowed  (out_ch.entry_allowed)
);
